[design/dcq_pkg.sv]
// ----------------------------------------------------------------------------
// Duplicate-suppressing circular queue: shared definitions
// Operation codes, result status codes, and the command and status groups
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package dcq_pkg;

   // Width of the key ports and the occupancy port.
   localparam int KEY_W = 64;
   localparam int OCC_W = 5;

   // Operation requested on the input channel.
   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   // Status reported with every result.
   typedef enum logic [1:0] {
      RSP_OK    = 2'd0,
      RSP_FULL  = 2'd1,
      RSP_EMPTY = 2'd2,
      RSP_DUP   = 2'd3
   } rsp_code_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load_key;
      logic         scan_start;
      logic         scan_en;
      logic         deq_read;
      logic         deq_pop;
      logic         push_first;
      logic         push_append;
      logic         respond;
      rsp_code_type rsp_code;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic full;
      logic hit;
      logic scan_done;
   } dp_status_type;

endpackage

[design/dedup_circular_queue_top.sv]
// ----------------------------------------------------------------------------
// Duplicate-suppressing circular queue: top level
// A ring of fixed-width keys that refuses keys it already holds.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge at which start is high and busy is low;
// each request produces exactly one result, shown for a single cycle with
// rsp_strobe high, and the receiver has no means to hold it off, so it must
// capture the result on that cycle. Busy after the accepting edge: a dequeue
// from an empty queue, an enqueue into a full queue and an enqueue into an
// empty queue are decided at once and never raise busy; a dequeue from a
// non-empty queue keeps busy high for the registered read of the oldest slot;
// an enqueue into a non-empty queue keeps busy high for the duplicate search,
// which reads one stored key per cycle through the single read port of the
// key memory and compares it with the offered key (it stops early on a match).
// The result appears on the cycle after the decision. The longest search runs
// over DEPTH - 1 held keys, since a full queue rejects at once. The key memory
// needs no clearing after reset, so the block takes requests as soon as reset
// is released.
// Only the low KEY_BITS bits of a key are stored and compared; the occupancy
// reports the number of keys held after the request, masked to five bits.
// ----------------------------------------------------------------------------
module dedup_circular_queue_top
   import dcq_pkg::*;
#(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [KEY_W-1:0]   req_key_in,
   output logic               rsp_strobe,
   output logic [KEY_W-1:0]   rsp_key_out,
   output logic [1:0]         rsp_status,
   output logic [OCC_W-1:0]   rsp_occupancy
);

   // Commands flow from the controller to the datapath, status flows back.
   cmd_type       cmd;
   dp_status_type dp_status;

   // The controller decides each request and steps the search or the read.
   dcq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_func),
      .dp_status (dp_status),
      .cmd       (cmd),
      .busy      (busy)
   );

   // The datapath holds the keys, the pointers and the result registers.
   dcq_datapath #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_key_in    (req_key_in),
      .dp_status     (dp_status),
      .rsp_strobe    (rsp_strobe),
      .rsp_key_out   (rsp_key_out),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

[design/dcq_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dcq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/dcq_ctrl.sv]
// ----------------------------------------------------------------------------
// Duplicate-suppressing circular queue: controller
// Sequences each request through the decision, the duplicate search and the
// dequeue read, and tells the datapath when to respond.
// ----------------------------------------------------------------------------
module dcq_ctrl
   import dcq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_func,
   input  dp_status_type dp_status,
   output cmd_type       cmd,
   output logic          busy
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DEQ  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_code = RSP_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_key = 1'b1;
               if (req_func == FUNC_DEQ) begin
                  if (dp_status.empty) begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_code = RSP_EMPTY;
                  end else begin
                     cmd.deq_read = 1'b1;
                     state_in     = ST_DEQ;
                  end
               end else if (dp_status.full) begin
                  cmd.respond  = 1'b1;
                  cmd.rsp_code = RSP_FULL;
               end else if (dp_status.empty) begin
                  cmd.push_first = 1'b1;
                  cmd.respond    = 1'b1;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_DEQ: begin
            cmd.deq_pop = 1'b1;
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (dp_status.hit) begin
               cmd.respond  = 1'b1;
               cmd.rsp_code = RSP_DUP;
               state_in     = ST_IDLE;
            end else if (dp_status.scan_done) begin
               cmd.push_append = 1'b1;
               cmd.respond     = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[design/dcq_datapath.sv]
// ----------------------------------------------------------------------------
// Duplicate-suppressing circular queue: datapath
// Pointers, occupancy count, key store, sequential duplicate search and the
// result registers.
// ----------------------------------------------------------------------------
module dcq_datapath
   import dcq_pkg::*;
#(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [KEY_W-1:0]   req_key_in,
   output dp_status_type      dp_status,
   output logic               rsp_strobe,
   output logic [KEY_W-1:0]   rsp_key_out,
   output logic [1:0]         rsp_status,
   output logic [OCC_W-1:0]   rsp_occupancy
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PTR_W-1:0]    scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [KEY_BITS-1:0] key_ff;

   logic                rsp_strobe_ff;
   logic [KEY_W-1:0]    rsp_key_out_ff, rsp_key_out_in;
   rsp_code_type        rsp_status_ff;
   logic [OCC_W-1:0]    rsp_occupancy_ff;
   logic [CNT_W+OCC_W-1:0] occ_wide;

   logic                ram_wr_en;
   logic [PTR_W-1:0]    ram_wr_addr;
   logic [KEY_BITS-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [PTR_W-1:0]    ram_rd_addr;
   logic [KEY_BITS-1:0] ram_rd_data;
   logic                scan_issue;

   function automatic logic [PTR_W-1:0] next_index(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   dcq_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // A search read is issued only while keys remain to be fetched.
   assign scan_issue = cmd.scan_en && (rem_ff != '0);

   assign ram_wr_en   = cmd.push_first || cmd.push_append;
   assign ram_wr_addr = cmd.push_first ? '0 : next_index(tail_ff);
   assign ram_wr_data = cmd.push_first ? req_key_in[KEY_BITS-1:0] : key_ff;
   assign ram_rd_en   = cmd.deq_read || scan_issue;
   assign ram_rd_addr = cmd.deq_read ? head_ff : scan_ptr_ff;

   assign dp_status.empty     = (count_ff == '0);
   assign dp_status.full      = (count_ff == CNT_W'(DEPTH));
   assign dp_status.hit       = rd_valid_ff && (ram_rd_data == key_ff);
   assign dp_status.scan_done = (rem_ff == '0) && !rd_valid_ff;

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      scan_ptr_in = scan_ptr_ff;
      rem_in      = rem_ff;
      rd_valid_in = scan_issue;

      if (cmd.scan_start) begin
         scan_ptr_in = head_ff;
         rem_in      = count_ff;
      end else if (scan_issue) begin
         scan_ptr_in = next_index(scan_ptr_ff);
         rem_in      = rem_ff - 1'b1;
      end

      if (cmd.push_first) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = CNT_W'(1);
      end else if (cmd.push_append) begin
         tail_in  = next_index(tail_ff);
         count_in = count_ff + 1'b1;
      end else if (cmd.deq_pop) begin
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            head_in = '0;
            tail_in = '0;
         end else begin
            head_in = next_index(head_ff);
         end
      end
   end

   assign rsp_key_out_in = cmd.deq_pop ? KEY_W'(ram_rd_data) : '0;
   assign occ_wide       = (CNT_W + OCC_W)'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         scan_ptr_ff   <= '0;
         rem_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         scan_ptr_ff   <= scan_ptr_in;
         rem_ff        <= rem_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         key_ff <= req_key_in[KEY_BITS-1:0];
      end
      if (cmd.respond) begin
         rsp_key_out_ff   <= rsp_key_out_in;
         rsp_status_ff    <= cmd.rsp_code;
         rsp_occupancy_ff <= occ_wide[OCC_W-1:0];
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_key_out   = rsp_key_out_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

   // The count never goes beyond the number of slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy count exceeds the queue depth");

   // An empty queue always has both pointers parked at slot zero.
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty queue with pointers away from slot zero");

   // A rejected or failed request leaves the occupancy untouched.
   a_reject_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff != RSP_OK) |-> $stable(count_ff))
      else $error("occupancy changed on a request that was not carried out");

   // A search never runs past the number of keys that were held at its start.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_en |-> (rem_ff <= count_ff))
      else $error("duplicate search outruns the held keys");

endmodule
